FILE: sv/approximate_pattern_matcher_unit_macros.svh
// Assertion helpers used by the matcher top module.
`ifndef APPROXIMATE_PATTERN_MATCHER_UNIT_MACROS_SVH
`define APPROXIMATE_PATTERN_MATCHER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define APM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("apm assertion failed");

// Next-cycle implication, checked outside reset.
`define APM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("apm assertion failed");

`endif

FILE: sv/apm_pkg.sv
package apm_pkg;

    localparam int DIST_W = 5;

    localparam logic [1:0] REG_PAT_LO  = 2'd0;
    localparam logic [1:0] REG_PAT_HI  = 2'd1;
    localparam logic [1:0] REG_PAT_LEN = 2'd2;
    localparam logic [1:0] REG_MAX_ERR = 2'd3;

    typedef struct packed {
        logic              valid;
        logic [7:0]        text_byte;
        logic [DIST_W-1:0] old_d;
        logic [DIST_W-1:0] new_d;
        logic              match;
    } t_cell_data;

    typedef struct packed {
        logic [7:0]        pat_byte;
        logic [DIST_W-1:0] cap;
        logic [3:0]        max_err;
        logic              is_last;
    } t_cell_ctl;

endpackage

FILE: sv/approximate_pattern_matcher_unit.sv
// Channel   | Direction | Handshake                 | Payload
// text in   | input     | i_in_valid / o_in_ready   | i_text_byte
// result    | output    | o_out_valid / i_out_ready | o_match_found, o_text_position
// config    | input     | psel, penable, pwrite     | paddr, pwdata, prdata
//
// One item enters per cycle and flows down a row of MAX_PATTERN cells on a skewed schedule.
// Each item's result passes through the MAX_PATTERN cell registers, then the output register.
// Reset is synchronous and restores the distance column, the position count and the registers.
// When a result waits in the output register and is not taken, the whole row stalls.
`include "approximate_pattern_matcher_unit_macros.svh"

module approximate_pattern_matcher_unit #(
    parameter int MAX_PATTERN = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_text_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_match_found,
    output logic [31:0] o_text_position,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import apm_pkg::*;

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [63:0] r_pat_lo;
    logic [63:0] r_pat_hi;
    logic [4:0]  r_pat_len;
    logic [3:0]  r_max_err;
    logic        r_out_valid;
    logic        r_out_match;
    logic [31:0] r_pos;

    logic             w_en;
    logic             w_wr;
    logic [6:0]       w_len_ext;
    logic [IDX_W-1:0] w_last_idx;
    logic [DIST_W-1:0] w_cap;
    t_cell_data       w_chain [MAX_PATTERN+1];

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
            r_pat_len <= 5'd1;
            r_max_err <= '0;
        end else if (w_wr) begin
            unique case (paddr[4:3])
                REG_PAT_LO:  r_pat_lo  <= pwdata;
                REG_PAT_HI:  r_pat_hi  <= pwdata;
                REG_PAT_LEN: r_pat_len <= pwdata[4:0];
                REG_MAX_ERR: r_max_err <= pwdata[3:0];
                default:     r_pat_lo  <= r_pat_lo;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:3])
            REG_PAT_LO:  prdata = r_pat_lo;
            REG_PAT_HI:  prdata = r_pat_hi;
            REG_PAT_LEN: prdata = {59'd0, r_pat_len};
            REG_MAX_ERR: prdata = {60'd0, r_max_err};
            default:     prdata = '0;
        endcase
    end

    always_comb begin
        w_len_ext = {2'b00, r_pat_len};
        if (r_pat_len == 5'd0) begin
            w_last_idx = '0;
        end else if (w_len_ext > 7'(MAX_PATTERN)) begin
            w_last_idx = IDX_W'(MAX_PATTERN - 1);
        end else begin
            w_last_idx = IDX_W'(w_len_ext - 7'd1);
        end
        w_cap = {1'b0, r_max_err} + DIST_W'(1);
    end

    assign w_en       = !r_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    always_comb begin
        w_chain[0].valid     = i_in_valid;
        w_chain[0].text_byte = i_text_byte;
        w_chain[0].old_d     = '0;
        w_chain[0].new_d     = '0;
        w_chain[0].match     = 1'b0;
    end

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        t_cell_ctl w_ctl;

        always_comb begin
            if (k < 8) begin
                w_ctl.pat_byte = r_pat_lo[(8*(k%8)) +: 8];
            end else if (k < 16) begin
                w_ctl.pat_byte = r_pat_hi[(8*(k%8)) +: 8];
            end else begin
                w_ctl.pat_byte = 8'h00;
            end
            w_ctl.cap     = w_cap;
            w_ctl.max_err = r_max_err;
            w_ctl.is_last = (w_last_idx == IDX_W'(k));
        end

        apm_cell #(
            .CELL_IDX(k)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_ctl  (w_ctl),
            .i_data (w_chain[k]),
            .o_data (w_chain[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pos       <= '0;
        end else begin
            if (w_en) begin
                r_out_valid <= w_chain[MAX_PATTERN].valid;
            end
            if (r_out_valid && i_out_ready) begin
                r_pos <= r_pos + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_match <= w_chain[MAX_PATTERN].match;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_match_found   = r_out_match;
    assign o_text_position = r_pos;

    `APM_ASSERT_NOW(a_stall_blocks_input, r_out_valid && !i_out_ready, !o_in_ready)
    `APM_ASSERT_NEXT(a_pos_steps, r_out_valid && i_out_ready, r_pos == $past(r_pos) + 32'd1)
    `APM_ASSERT_NOW(a_first_row_bound, w_chain[1].valid, w_chain[1].new_d <= DIST_W'(1))
    `APM_ASSERT_NOW(a_valid_drops_on_take, $fell(r_out_valid), $past(i_out_ready))

endmodule

FILE: sv/apm_cell.sv
module apm_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  apm_pkg::t_cell_ctl  i_ctl,
    input  apm_pkg::t_cell_data i_data,
    output apm_pkg::t_cell_data o_data
);
    import apm_pkg::*;

    logic [DIST_W-1:0] r_dist;
    logic [DIST_W-1:0] n_dist;
    t_cell_data        r_data;
    t_cell_data        n_data;
    logic              w_cost;
    logic [DIST_W:0]   w_a;
    logic [DIST_W:0]   w_b;
    logic [DIST_W:0]   w_c;
    logic [DIST_W:0]   w_ab;
    logic [DIST_W:0]   w_abc;
    logic [DIST_W:0]   w_v;

    always_comb begin
        w_cost = (i_data.text_byte != i_ctl.pat_byte);
        w_a    = {1'b0, r_dist} + (DIST_W+1)'(1);
        w_b    = {1'b0, i_data.new_d} + (DIST_W+1)'(1);
        w_c    = {1'b0, i_data.old_d} + {{DIST_W{1'b0}}, w_cost};
        w_ab   = (w_a < w_b) ? w_a : w_b;
        w_abc  = (w_ab < w_c) ? w_ab : w_c;
        w_v    = (w_abc < {1'b0, i_ctl.cap}) ? w_abc : {1'b0, i_ctl.cap};
        n_dist = w_v[DIST_W-1:0];

        n_data.valid     = i_data.valid;
        n_data.text_byte = i_data.text_byte;
        n_data.old_d     = r_dist;
        n_data.new_d     = n_dist;
        n_data.match     = i_ctl.is_last ? (w_v <= {2'b00, i_ctl.max_err}) : i_data.match;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist <= DIST_W'(CELL_IDX + 1);
            r_data <= '0;
        end else if (i_en) begin
            r_data <= n_data;
            if (i_data.valid) begin
                r_dist <= n_dist;
            end
        end
    end

    assign o_data = r_data;

endmodule
